[rtl/fmop_pkg.sv]
// Package for the FM operator: command and envelope stage codes, register
// indexes, fixed widths and the sine table entry function.
// No dependencies.
`timescale 1ns / 1ps

package fmop_pkg;

  // input commands
  localparam logic [1:0] CMD_TICK     = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd2;

  // envelope stages
  localparam logic [2:0] STG_IDLE    = 3'd0;
  localparam logic [2:0] STG_ATTACK  = 3'd1;
  localparam logic [2:0] STG_DECAY   = 3'd2;
  localparam logic [2:0] STG_SUSTAIN = 3'd3;
  localparam logic [2:0] STG_RELEASE = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_PHASE_STEP    = 3'd0;
  localparam logic [2:0] REG_ATTACK_COEFF  = 3'd1;
  localparam logic [2:0] REG_DECAY_COEFF   = 3'd2;
  localparam logic [2:0] REG_RELEASE_COEFF = 3'd3;
  localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd4;
  localparam logic [2:0] REG_FEEDBACK_GAIN = 3'd5;
  localparam logic [2:0] REG_OUTPUT_LEVEL  = 3'd6;

  localparam int CFG_W   = 24;
  localparam int Q16_W   = 17;
  localparam logic [Q16_W-1:0] ONE_Q16 = 17'd65536;

  // shared multiplier: signed a times unsigned b
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef logic signed [15:0] sample_t;

  // round(32767*sin(2*pi*k/N)) with N = 2**abits, Q30 folded Taylor series
  function automatic sample_t sine_entry(input longint unsigned k, input int abits);
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] kk;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    n    = 64'd1 << abits;
    q    = n >> 2;
    kk   = k & (n - 64'd1);
    quad = kk >> (abits - 2);
    r    = kk & (q - 64'd1);
    m    = quad[0] ? (q - r) : r;
    x    = (64'd1686629713 * m) >> (abits - 2);
    x2   = (x * x) >> 30;
    t    = 64'd1073741824 - x2 / 72;
    t    = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t    = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t    = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s    = (x * t) >> 30;
    v    = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (quad >= 64'd2) ? -sample_t'(v[15:0]) : sample_t'(v[15:0]);
  endfunction

endpackage

[rtl/fmop_mul.sv]
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on fmop_pkg for operand widths.
`timescale 1ns / 1ps

module fmop_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [fmop_pkg::MUL_A_W-1:0]   a,
  input  logic        [fmop_pkg::MUL_B_W-1:0]   b,
  output logic signed [fmop_pkg::MUL_P_W-1:0]   prod_r
);
  import fmop_pkg::*;

  logic signed [MUL_B_W:0] b_s;

  assign b_s = $signed({1'b0, b});

  // hold the product while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= MUL_P_W'(a) * MUL_P_W'(b_s);
    end
  end

endmodule

[rtl/fmop_sine_rom.sv]
// Sine lookup table with registered read, built at elaboration.
// Depends on fmop_pkg for the entry function.
`timescale 1ns / 1ps

module fmop_sine_rom #(
  parameter int ADDR_BITS = 10
) (
  input  logic                  clk,
  input  logic [ADDR_BITS-1:0]  addr,
  output fmop_pkg::sample_t     data_r
);
  import fmop_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  sample_t rom_tbl [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    assign rom_tbl[k] = sine_entry(longint'(k), ADDR_BITS);
  end

  always_ff @(posedge clk) begin
    data_r <= rom_tbl[addr];
  end

endmodule

[rtl/fm_operator_adsr_unit.sv]
// FM operator with exponential ADSR envelope: sequencer, state and config.
// Depends on fmop_pkg, fmop_mul and fmop_sine_rom.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_stall, in_command, in_mod_in) takes one command
//   per item. Note-on and note-off update the envelope stage in the cycle they
//   are accepted and give no result. A sample tick gives one result item on
//   the output channel (out_valid/out_stall, out_sample, out_envelope,
//   out_stage). Unknown commands are dropped.
//   A tick runs through seven sequencer steps after acceptance: envelope
//   multiply, envelope update with feedback multiply, phase add, sine table
//   read, two scaling multiplies and rounding. The next item is taken only
//   after the result is loaded into the output register; all four products
//   share one multiplier.
//   in_stall is high while a tick is in work. If the receiver stalls, the
//   result holds in the output register; the next tick waits in its final
//   step until that register is free.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
//   belong in idle periods. Synchronous reset (rst_n low) restores register
//   defaults, sets the envelope idle at zero and clears phase and feedback.
module fm_operator_adsr_unit #(
  parameter int PHASE_BITS     = 24,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic signed [23:0]           in_mod_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           out_sample,
  output logic [16:0]                  out_envelope,
  output logic [2:0]                   out_stage,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [fmop_pkg::CFG_W-1:0]   cfg_data
);
  import fmop_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ENV     = 3'd1;
  localparam logic [2:0] S_ENV_UPD = 3'd2;
  localparam logic [2:0] S_PHASE   = 3'd3;
  localparam logic [2:0] S_ROM     = 3'd4;
  localparam logic [2:0] S_MUL1    = 3'd5;
  localparam logic [2:0] S_MUL2    = 3'd6;
  localparam logic [2:0] S_ROUND   = 3'd7;

  // configuration
  logic [23:0]       phase_step_r;
  logic [Q16_W-1:0]  attack_coeff_r;
  logic [Q16_W-1:0]  decay_coeff_r;
  logic [Q16_W-1:0]  release_coeff_r;
  logic [Q16_W-1:0]  sustain_level_r;
  logic [15:0]       feedback_gain_r;
  logic [Q16_W-1:0]  output_level_r;

  // operator state
  logic [2:0]            state_r, state_nxt;
  logic [2:0]            env_stage_r, env_stage_nxt;
  logic [Q16_W-1:0]      env_level_r, env_level_nxt;
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  sample_t               fb_new_r, fb_old_r;
  logic signed [23:0]    mod_r;
  logic                  out_valid_r;
  sample_t               out_sample_r;
  logic [Q16_W-1:0]      out_env_r;
  logic [2:0]            out_stage_r;

  // shared datapath
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic signed [MUL_P_W-1:0] mul_r;
  sample_t                   rom_data;

  logic                 in_fire;
  logic                 out_load;
  logic [Q16_W-1:0]     sus;
  logic [Q16_W-1:0]     target;
  logic [Q16_W-1:0]     coeff;
  logic signed [17:0]   diff;
  logic                 diff_neg;
  logic [Q16_W-1:0]     mag;
  logic [34:0]          step_sum;
  logic [18:0]          step;
  logic signed [20:0]   stepped;
  logic [Q16_W-1:0]     lvl;
  logic signed [17:0]   sus_d;
  logic signed [16:0]   fb_sum;
  logic signed [MUL_P_W-1:0] fb_shift;
  logic [MUL_P_W-1:0]   ph_sum;
  logic                 p_neg;
  logic [MUL_P_W-1:0]   p_mag;
  logic [MUL_P_W-1:0]   p_rnd;
  logic [19:0]          s_mag;
  sample_t              s_val;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_load  = (state_r == S_ROUND) && !(out_valid_r && out_stall);

  // hold the final product while the result waits for the output register
  assign mul_en    = (state_r != S_ROUND);

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_envelope = out_env_r;
  assign out_stage    = out_stage_r;

  assign sus = (sustain_level_r > ONE_Q16) ? ONE_Q16 : sustain_level_r;

  // envelope step toward the stage target
  always_comb begin
    unique case (env_stage_r)
      STG_ATTACK: begin
        target = ONE_Q16;
        coeff  = attack_coeff_r;
      end
      STG_DECAY: begin
        target = sus;
        coeff  = decay_coeff_r;
      end
      STG_RELEASE: begin
        target = '0;
        coeff  = release_coeff_r;
      end
      default: begin
        target = env_level_r;
        coeff  = '0;
      end
    endcase
  end

  assign diff     = $signed({1'b0, target}) - $signed({1'b0, env_level_r});
  assign diff_neg = diff[17];
  assign mag      = diff_neg ? Q16_W'(-diff) : Q16_W'(diff);
  assign step_sum = mul_r[34:0] + 35'd65535;
  assign step     = step_sum[34:16];
  assign stepped  = diff_neg ? (21'($signed({1'b0, env_level_r})) - $signed({2'b0, step}))
                             : (21'($signed({1'b0, env_level_r})) + $signed({2'b0, step}));

  always_comb begin
    if (stepped < 21'sd0) begin
      lvl = '0;
    end else if (stepped > 21'sd65536) begin
      lvl = ONE_Q16;
    end else begin
      lvl = stepped[16:0];
    end
  end

  assign sus_d = $signed({1'b0, lvl}) - $signed({1'b0, sus});

  // feedback and phase
  assign fb_sum   = 17'(fb_new_r) + 17'(fb_old_r);
  assign fb_shift = mul_r >>> 10;
  assign ph_sum   = MUL_P_W'(phase_acc_r) + MUL_P_W'(phase_step_r) + MUL_P_W'(mod_r)
                  + MUL_P_W'(fb_shift);

  // final rounding, ties away from zero, then saturate
  assign p_neg = mul_r[MUL_P_W-1];
  assign p_mag = p_neg ? MUL_P_W'(-mul_r) : MUL_P_W'(mul_r);
  assign p_rnd = p_mag + (MUL_P_W'(1) << 31);
  assign s_mag = p_rnd[51:32];

  always_comb begin
    if (!p_neg) begin
      s_val = (s_mag > 20'd32767) ? 16'sd32767 : sample_t'(s_mag[15:0]);
    end else begin
      s_val = (s_mag > 20'd32768) ? -16'sd32768 : -sample_t'(s_mag[15:0]);
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      S_ENV: begin
        mul_a = MUL_A_W'($signed({1'b0, mag}));
        mul_b = coeff;
      end
      S_ENV_UPD: begin
        mul_a = MUL_A_W'(fb_sum);
        mul_b = MUL_B_W'(feedback_gain_r);
      end
      S_MUL1: begin
        mul_a = MUL_A_W'(rom_data);
        mul_b = output_level_r;
      end
      S_MUL2: begin
        mul_a = mul_r[MUL_A_W-1:0];
        mul_b = env_level_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer and envelope state
  always_comb begin
    state_nxt     = state_r;
    env_stage_nxt = env_stage_r;
    env_level_nxt = env_level_r;
    phase_acc_nxt = phase_acc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_command)
            CMD_TICK: state_nxt = S_ENV;
            CMD_NOTE_ON: begin
              if (env_stage_r == STG_IDLE) begin
                env_level_nxt = '0;
              end
              env_stage_nxt = STG_ATTACK;
            end
            CMD_NOTE_OFF: begin
              if (env_stage_r != STG_IDLE) begin
                env_stage_nxt = STG_RELEASE;
              end
            end
            default: ;
          endcase
        end
      end
      S_ENV:     state_nxt = S_ENV_UPD;
      S_ENV_UPD: begin
        state_nxt = S_PHASE;
        unique case (env_stage_r)
          STG_ATTACK: begin
            if (lvl > 17'd65470) begin
              env_level_nxt = ONE_Q16;
              env_stage_nxt = STG_DECAY;
            end else begin
              env_level_nxt = lvl;
            end
          end
          STG_DECAY: begin
            if (sus_d <= 18'sd65 && sus_d >= -18'sd65) begin
              env_level_nxt = sus;
              env_stage_nxt = STG_SUSTAIN;
            end else begin
              env_level_nxt = lvl;
            end
          end
          STG_SUSTAIN: ;
          STG_RELEASE: begin
            env_level_nxt = lvl;
            if (lvl == '0) begin
              env_stage_nxt = STG_IDLE;
            end
          end
          default: begin
            env_level_nxt = '0;
            env_stage_nxt = STG_IDLE;
          end
        endcase
      end
      S_PHASE: begin
        state_nxt     = S_ROM;
        phase_acc_nxt = ph_sum[PHASE_BITS-1:0];
      end
      S_ROM:   state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_ROUND;
      S_ROUND: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      env_stage_r <= STG_IDLE;
      env_level_r <= '0;
      phase_acc_r <= '0;
      fb_new_r    <= '0;
      fb_old_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_stage_r <= env_stage_nxt;
      env_level_r <= env_level_nxt;
      phase_acc_r <= phase_acc_nxt;
      if (out_load) begin
        fb_old_r <= fb_new_r;
        fb_new_r <= s_val;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mod_r <= in_mod_in;
    end
    if (out_load) begin
      out_sample_r <= s_val;
      out_env_r    <= env_level_r;
      out_stage_r  <= env_stage_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r    <= '0;
      attack_coeff_r  <= ONE_Q16;
      decay_coeff_r   <= ONE_Q16;
      release_coeff_r <= ONE_Q16;
      sustain_level_r <= ONE_Q16;
      feedback_gain_r <= '0;
      output_level_r  <= ONE_Q16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP:    phase_step_r    <= cfg_data[23:0];
        REG_ATTACK_COEFF:  attack_coeff_r  <= cfg_data[16:0];
        REG_DECAY_COEFF:   decay_coeff_r   <= cfg_data[16:0];
        REG_RELEASE_COEFF: release_coeff_r <= cfg_data[16:0];
        REG_SUSTAIN_LEVEL: sustain_level_r <= cfg_data[16:0];
        REG_FEEDBACK_GAIN: feedback_gain_r <= cfg_data[15:0];
        REG_OUTPUT_LEVEL:  output_level_r  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  fmop_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_r)
  );

  fmop_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .addr   (phase_acc_r[PHASE_BITS-1 -: SINE_ADDR_BITS]),
    .data_r (rom_data)
  );

  // envelope never leaves [0, 1.0]
  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_level_r <= ONE_Q16)
    else $error("envelope above full scale");

  // an idle envelope sits at zero
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    env_stage_r == STG_IDLE |-> env_level_r == '0)
    else $error("idle envelope not zero");

  // sustain holds its level
  a_sustain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    env_stage_r == STG_SUSTAIN && state_r != S_IDLE |=> $stable(env_level_r))
    else $error("envelope moved in sustain");

  // a finished tick always leaves a result waiting
  a_round_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("tick result lost");

endmodule
